// File: hw/rtl/assert_macros.svh
// assertion macros for the port level checks in pvd_chk
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PVD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// checked at every edge, reset included
`define PVD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// File: hw/rtl/pvd_pkg.sv
// shared types, constants and range tables for the pixel pair embedder
// no dependencies

`default_nettype none

package pvd_pkg;

  localparam int PIX_W     = 8;
  localparam int WIN_W     = 7;
  localparam int CNT_W     = 3;
  localparam int RNG_W     = 3;
  localparam int PIXEL_MAX = 255;
  // signed working width for pixel plus or minus half a range
  localparam int SUM_W     = PIX_W + 2;

  typedef struct packed {
    logic [PIX_W-1:0] first_pixel;
    logic [PIX_W-1:0] second_pixel;
    logic [WIN_W-1:0] message_window;
    logic [CNT_W-1:0] message_count;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] first_out;
    logic [PIX_W-1:0] second_out;
    logic [CNT_W-1:0] bits_used;
  } out_item_t;

  // range of the absolute difference: 0-7, 8-15, 16-31, 32-63, 64-127, 128-255
  function automatic logic [RNG_W-1:0] range_sel(input logic [PIX_W-1:0] d);
    logic [RNG_W-1:0] r;
    if (d[7])      r = 3'd5;
    else if (d[6]) r = 3'd4;
    else if (d[5]) r = 3'd3;
    else if (d[4]) r = 3'd2;
    else if (d[3]) r = 3'd1;
    else           r = 3'd0;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] range_low(input logic [RNG_W-1:0] r);
    logic [PIX_W-1:0] v;
    case (r)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd8;
      3'd2:    v = 8'd16;
      3'd3:    v = 8'd32;
      3'd4:    v = 8'd64;
      default: v = 8'd128;
    endcase
    return v;
  endfunction

  function automatic logic [CNT_W-1:0] range_bits(input logic [RNG_W-1:0] r);
    logic [CNT_W-1:0] v;
    case (r)
      3'd0:    v = 3'd3;
      3'd1:    v = 3'd3;
      3'd2:    v = 3'd4;
      3'd3:    v = 3'd5;
      3'd4:    v = 3'd6;
      default: v = 3'd7;
    endcase
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pixel(input logic signed [SUM_W-1:0] v);
    logic [PIX_W-1:0] p;
    if (v < 0)                             p = '0;
    else if (v > $signed(SUM_W'(PIXEL_MAX))) p = PIX_W'(PIXEL_MAX);
    else                                   p = v[PIX_W-1:0];
    return p;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pvd_pair_embed.sv
// Pixel value differencing embedder for one channel of a horizontal pixel
// pair. Each transfer on the input side carries a pair and up to seven
// message bits; each transfer on the output side carries the new pair and
// the number of message bits it holds. One pair is taken per clock cycle when
// the output side keeps up. The pair is captured in the input register, goes
// through one stage of embed logic (difference, range lookup, split and
// saturate) and lands in the output register. Ready on the input side is low
// only when both registers hold an item and the output side stalls.
// depends on pvd_pkg and pvd_calc

`default_nettype none

module pvd_pair_embed (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pvd_pkg::PIX_W-1:0] first_pixel_i,
  input  logic [pvd_pkg::PIX_W-1:0] second_pixel_i,
  input  logic [pvd_pkg::WIN_W-1:0] message_window_i,
  input  logic [pvd_pkg::CNT_W-1:0] message_count_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pvd_pkg::PIX_W-1:0] first_out_o,
  output logic [pvd_pkg::PIX_W-1:0] second_out_o,
  output logic [pvd_pkg::CNT_W-1:0] bits_used_o
);

  logic                in_vld_q;
  pvd_pkg::in_item_t   in_q;
  pvd_pkg::in_item_t   in_d;
  logic                out_vld_q;
  pvd_pkg::out_item_t  out_q;
  pvd_pkg::out_item_t  res;
  logic                out_free;
  logic                in_free;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_free    = !in_vld_q || out_free;
  assign in_ready_o = in_free;

  assign in_d.first_pixel    = first_pixel_i;
  assign in_d.second_pixel   = second_pixel_i;
  assign in_d.message_window = message_window_i;
  assign in_d.message_count  = message_count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_free)  in_vld_q  <= in_valid_i;
      if (out_free) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) in_q  <= in_d;
    if (out_free && in_vld_q)  out_q <= res;
  end

  pvd_calc u_calc (
    .item_i (in_q),
    .res_o  (res)
  );

  assign out_valid_o  = out_vld_q;
  assign first_out_o  = out_q.first_out;
  assign second_out_o = out_q.second_out;
  assign bits_used_o  = out_q.bits_used;

endmodule

`default_nettype wire

// File: hw/rtl/pvd_calc.sv
// combinational embed of one pixel pair: range lookup, bit pick and split
// depends on pvd_pkg

`default_nettype none

module pvd_calc (
  input  pvd_pkg::in_item_t  item_i,
  output pvd_pkg::out_item_t res_o
);

  logic                              first_big;
  logic [pvd_pkg::PIX_W-1:0]         diff;
  logic [pvd_pkg::PIX_W-1:0]         big_pix;
  logic [pvd_pkg::PIX_W-1:0]         small_pix;
  logic [pvd_pkg::RNG_W-1:0]         rng;
  logic [pvd_pkg::PIX_W-1:0]         low;
  logic [pvd_pkg::CNT_W-1:0]         cap;
  logic [pvd_pkg::WIN_W-1:0]         mask;
  logic [pvd_pkg::WIN_W-1:0]         val;
  logic [pvd_pkg::PIX_W:0]           target_diff;
  logic signed [pvd_pkg::SUM_W-1:0]  delta;
  logic signed [pvd_pkg::SUM_W-1:0]  fl;
  logic signed [pvd_pkg::SUM_W-1:0]  ce;
  logic [pvd_pkg::PIX_W-1:0]         big_new;
  logic [pvd_pkg::PIX_W-1:0]         small_new;

  always_comb begin
    first_big = item_i.first_pixel >= item_i.second_pixel;
    big_pix   = first_big ? item_i.first_pixel : item_i.second_pixel;
    small_pix = first_big ? item_i.second_pixel : item_i.first_pixel;
    diff      = big_pix - small_pix;

    rng = pvd_pkg::range_sel(diff);
    low = pvd_pkg::range_low(rng);
    cap = pvd_pkg::range_bits(rng);

    // keep only the real message bits, msb first
    mask = ~({pvd_pkg::WIN_W{1'b1}} >> item_i.message_count);
    val  = (item_i.message_window & mask) >> (3'd7 - cap);

    target_diff = {1'b0, low} + {2'b00, val};
    delta       = $signed({1'b0, target_diff}) - $signed({2'b00, diff});
    // floor half, ceiling half
    fl = delta >>> 1;
    ce = delta - fl;

    big_new   = pvd_pkg::clamp_pixel($signed({2'b00, big_pix}) + ce);
    small_new = pvd_pkg::clamp_pixel($signed({2'b00, small_pix}) - fl);

    if (item_i.message_count == '0) begin
      res_o.first_out  = item_i.first_pixel;
      res_o.second_out = item_i.second_pixel;
      res_o.bits_used  = '0;
    end else begin
      res_o.first_out  = first_big ? big_new : small_new;
      res_o.second_out = first_big ? small_new : big_new;
      res_o.bits_used  = (item_i.message_count < cap) ? item_i.message_count : cap;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pvd_chk.sv
// port level checks for the pixel pair embedder, bound to the top level
// depends on pvd_pkg and assert_macros.svh

`default_nettype none

`include "assert_macros.svh"

module pvd_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [pvd_pkg::PIX_W-1:0] first_pixel_i,
  input logic [pvd_pkg::PIX_W-1:0] second_pixel_i,
  input logic [pvd_pkg::WIN_W-1:0] message_window_i,
  input logic [pvd_pkg::CNT_W-1:0] message_count_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [pvd_pkg::PIX_W-1:0] first_out_o,
  input logic [pvd_pkg::PIX_W-1:0] second_out_o,
  input logic [pvd_pkg::CNT_W-1:0] bits_used_o
);

  logic in_xfer;
  logic empty_msg;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign empty_msg = message_count_i == '0;

  // nothing shows on the output once reset has been seen at an edge
  `PVD_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o)

  // a stalled result holds
  `PVD_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_out_o) &&
    $stable(second_out_o) && $stable(bits_used_o))

  // an empty output register never blocks the input side
  `PVD_ASSERT(a_no_block, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

  // an empty message passes the pair through both registers unchanged, with no bits used
  `PVD_ASSERT(a_pass_thru, clk_i, rst_ni,
    in_xfer && empty_msg ##1 out_ready_i |=> out_valid_o && bits_used_o == '0 &&
    first_out_o == $past(first_pixel_i, 2) && second_out_o == $past(second_pixel_i, 2))

endmodule

bind pvd_pair_embed pvd_chk u_pvd_chk (.*);

`default_nettype wire

// File: test/pair_embed_checker.sv
// watches both sides of the pixel pair embedder, predicts each result
// on its own and compares it field by field; depends on pvd_pkg
`timescale 1ns / 100ps

module pair_embed_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [pvd_pkg::PIX_W-1:0] first_pixel_i,
  input  logic [pvd_pkg::PIX_W-1:0] second_pixel_i,
  input  logic [pvd_pkg::WIN_W-1:0] message_window_i,
  input  logic [pvd_pkg::CNT_W-1:0] message_count_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [pvd_pkg::PIX_W-1:0] first_out_i,
  input  logic [pvd_pkg::PIX_W-1:0] second_out_i,
  input  logic [pvd_pkg::CNT_W-1:0] bits_used_i,
  output int                        mismatches_o,
  output int                        pending_o
);

  pvd_pkg::out_item_t expected_pairs[$];

  function automatic logic [pvd_pkg::PIX_W-1:0] saturate_pixel(input int v);
    if (v < 0) return '0;
    if (v > pvd_pkg::PIXEL_MAX) return pvd_pkg::PIX_W'(pvd_pkg::PIXEL_MAX);
    return pvd_pkg::PIX_W'(v);
  endfunction

  function automatic pvd_pkg::out_item_t embed_pair(input pvd_pkg::in_item_t it);
    int p1, p2, cnt, diff, low, cap, val, delta, fl, ce, n1, n2;
    logic [pvd_pkg::WIN_W-1:0] kept;
    pvd_pkg::out_item_t r;
    p1  = it.first_pixel;
    p2  = it.second_pixel;
    cnt = it.message_count;
    r.first_out  = it.first_pixel;
    r.second_out = it.second_pixel;
    r.bits_used  = '0;
    if (cnt != 0) begin
      diff = (p1 >= p2) ? p1 - p2 : p2 - p1;
      if (diff < 8) begin
        low = 0;   cap = 3;
      end else if (diff < 16) begin
        low = 8;   cap = 3;
      end else if (diff < 32) begin
        low = 16;  cap = 4;
      end else if (diff < 64) begin
        low = 32;  cap = 5;
      end else if (diff < 128) begin
        low = 64;  cap = 6;
      end else begin
        low = 128; cap = 7;
      end
      // bits past the message end read as zero
      kept  = it.message_window & ~(7'h7f >> cnt);
      val   = kept >> (pvd_pkg::WIN_W - cap);
      delta = low + val - diff;
      fl    = delta >>> 1;
      ce    = delta - fl;
      // larger pixel (left on a tie) takes the ceiling half
      if (p1 >= p2) begin
        n1 = p1 + ce;
        n2 = p2 - fl;
      end else begin
        n1 = p1 - fl;
        n2 = p2 + ce;
      end
      r.first_out  = saturate_pixel(n1);
      r.second_out = saturate_pixel(n2);
      r.bits_used  = pvd_pkg::CNT_W'((cnt < cap) ? cnt : cap);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    pvd_pkg::in_item_t  item;
    pvd_pkg::out_item_t want;
    int                 errs;
    errs = 0;
    if (!rst_ni) begin
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        item.first_pixel    = first_pixel_i;
        item.second_pixel   = second_pixel_i;
        item.message_window = message_window_i;
        item.message_count  = message_count_i;
        expected_pairs.insert(expected_pairs.size(), embed_pair(item));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: result transfer with nothing expected: %0d %0d %0d",
                   $time, first_out_i, second_out_i, bits_used_i);
          errs++;
        end else begin
          want = expected_pairs.pop_front();
          if (first_out_i !== want.first_out) begin
            $display("%0t: first_out expected %0d, got %0d",
                     $time, want.first_out, first_out_i);
            errs++;
          end
          if (second_out_i !== want.second_out) begin
            $display("%0t: second_out expected %0d, got %0d",
                     $time, want.second_out, second_out_i);
            errs++;
          end
          if (bits_used_i !== want.bits_used) begin
            $display("%0t: bits_used expected %0d, got %0d",
                     $time, want.bits_used, bits_used_i);
            errs++;
          end
        end
      end
      mismatches_o <= mismatches_o + errs;
      pending_o    <= expected_pairs.size();
    end
  end

endmodule

// File: test/tb.sv
// stimulus for the pixel pair embedder: directed corner pairs, then random
// pairs under changing idle patterns; depends on pvd_pkg, pvd_pair_embed
// and pair_embed_checker
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 60;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [pvd_pkg::PIX_W-1:0] first_pixel;
  logic [pvd_pkg::PIX_W-1:0] second_pixel;
  logic [pvd_pkg::WIN_W-1:0] message_window;
  logic [pvd_pkg::CNT_W-1:0] message_count;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [pvd_pkg::PIX_W-1:0] first_out;
  logic [pvd_pkg::PIX_W-1:0] second_out;
  logic [pvd_pkg::CNT_W-1:0] bits_used;

  int mismatches;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_reqs;
  int holds_done = 0;
  int hold_left  = 0;
  int cycles     = 0;

  pvd_pair_embed dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .first_pixel_i    (first_pixel),
    .second_pixel_i   (second_pixel),
    .message_window_i (message_window),
    .message_count_i  (message_count),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .first_out_o      (first_out),
    .second_out_o     (second_out),
    .bits_used_o      (bits_used)
  );

  pair_embed_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .first_pixel_i    (first_pixel),
    .second_pixel_i   (second_pixel),
    .message_window_i (message_window),
    .message_count_i  (message_count),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .first_out_i      (first_out),
    .second_out_i     (second_out),
    .bits_used_i      (bits_used),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      out_ready  <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pair(input logic [pvd_pkg::PIX_W-1:0] a,
                           input logic [pvd_pkg::PIX_W-1:0] b,
                           input logic [pvd_pkg::WIN_W-1:0] win,
                           input logic [pvd_pkg::CNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    first_pixel    <= a;
    second_pixel   <= b;
    message_window <= win;
    message_count  <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_pair();
    logic [pvd_pkg::PIX_W-1:0] a, b;
    int                        mode;
    mode = $urandom_range(9);
    a    = pvd_pkg::PIX_W'($urandom_range(255));
    b    = pvd_pkg::PIX_W'($urandom_range(255));
    case (mode)
      0: b = a;
      1: begin
        // one pixel pinned to an end of the scale
        a = $urandom_range(1) ? 8'd255 : 8'd0;
        b = pvd_pkg::PIX_W'($urandom_range(255));
      end
      2: b = a ^ pvd_pkg::PIX_W'($urandom_range(15));
      default: ;
    endcase
    if ($urandom_range(1)) send_pair(a, b, pvd_pkg::WIN_W'($urandom_range(127)),
                                     pvd_pkg::CNT_W'($urandom_range(7)));
    else send_pair(b, a, pvd_pkg::WIN_W'($urandom_range(127)),
                   pvd_pkg::CNT_W'($urandom_range(7)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    first_pixel    = '0;
    second_pixel   = '0;
    message_window = '0;
    message_count  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 24;
    recv_stall_pct = 51;

    // empty message, equal pixels, saturation at both ends
    send_pair(8'd200, 8'd10,  7'h7f, 3'd0);
    send_pair(8'd0,   8'd0,   7'h7f, 3'd7);
    send_pair(8'd255, 8'd255, 7'h7f, 3'd7);
    send_pair(8'd0,   8'd255, 7'h00, 3'd7);
    send_pair(8'd255, 8'd0,   7'h7f, 3'd7);
    send_pair(8'd0,   8'd5,   7'h7f, 3'd3);
    send_pair(8'd250, 8'd255, 7'h7f, 3'd3);
    // range edges of the difference
    send_pair(8'd7,   8'd0,   7'h55, 3'd7);
    send_pair(8'd0,   8'd8,   7'h2a, 3'd7);
    send_pair(8'd15,  8'd0,   7'h00, 3'd7);
    send_pair(8'd0,   8'd16,  7'h7f, 3'd7);
    send_pair(8'd40,  8'd9,   7'h33, 3'd7);
    send_pair(8'd9,   8'd41,  7'h4c, 3'd7);
    send_pair(8'd63,  8'd0,   7'h1f, 3'd7);
    send_pair(8'd100, 8'd164, 7'h60, 3'd7);
    send_pair(8'd127, 8'd0,   7'h7f, 3'd7);
    send_pair(8'd0,   8'd128, 7'h01, 3'd7);
    // short messages, with and without spare capacity
    send_pair(8'd200, 8'd60,  7'h7f, 3'd3);
    send_pair(8'd100, 8'd90,  7'h7f, 3'd5);
    send_pair(8'd50,  8'd20,  7'h2a, 3'd6);
    send_pair(8'd20,  8'd50,  7'h7f, 3'd1);
    send_pair(8'd30,  8'd160, 7'h7f, 3'd2);
    send_pair(8'd128, 8'd0,   7'h7f, 3'd4);

    for (int i = 0; i < 200; i++) begin
      if (i == 60) hold_reqs++;
      send_random_pair();
    end

    send_idle_pct  = 51;
    recv_stall_pct = 24;
    for (int i = 0; i < 200; i++) begin
      if (i == 100) wait_drained();
      send_random_pair();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 200; i++) begin
      if (i == 50) hold_reqs++;
      send_random_pair();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
